// File: rtl/core/xtl_pkg.sv
`default_nettype none

package xtl_pkg;

    // Counter widths of the token record.
    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    // Characters that steer the lexer.
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Token kinds.
    typedef enum logic [1:0] {
        KIND_ELEMENT   = 2'd0,
        KIND_TEXT      = 2'd1,
        KIND_ATTRIBUTE = 2'd2
    } t_token_kind;

    // One input transaction.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    // One token record.
    typedef struct packed {
        t_token_kind              token_kind;
        logic [LINE_BITS-1:0]     line_number;
        logic [COLUMN_BITS-1:0]   column_number;
        logic [OFFSET_BITS-1:0]   start_offset;
        logic                     has_label;
        logic                     is_final;
    } t_out_item;

    // Character classes of one byte.
    typedef struct packed {
        logic is_lt;
        logic is_gt;
        logic is_quote;
        logic is_newline;
        logic is_blank;
        logic is_separator;
    } t_char_class;

endpackage

`default_nettype wire

// File: rtl/core/xtl_char_class.sv
`default_nettype none

module xtl_char_class (
    input  wire logic [7:0]          i_byte,
    output xtl_pkg::t_char_class     o_class
);
    import xtl_pkg::*;

    // Decode the byte into the classes the lexer acts on.
    always_comb begin
        o_class.is_lt        = (i_byte == CHAR_LT);
        o_class.is_gt        = (i_byte == CHAR_GT);
        o_class.is_quote     = (i_byte == CHAR_QUOTE);
        o_class.is_newline   = (i_byte == CHAR_LF);
        o_class.is_blank     = (i_byte == CHAR_SPACE) || (i_byte == CHAR_TAB);
        o_class.is_separator = (i_byte == CHAR_SPACE) || (i_byte == CHAR_TAB) ||
                               (i_byte == CHAR_CR) || (i_byte == CHAR_SLASH);
    end

endmodule

`default_nettype wire

// File: rtl/core/xml_token_start_lexer.sv
// XML token start lexer.
// The input channel (i_in_valid / o_in_ready / i_in_data) carries one byte of
// XML text per transaction, or an end marker that carries no byte. The output
// channel (o_out_valid / i_out_ready / o_out_data) carries one token record
// for each byte that opens a label, and one final record for each end marker.
// Bytes that open no label give no output transaction.
// Every transaction is decided in the cycle it is accepted; its record sits in
// the output register from the next cycle on, and the block takes one byte per
// cycle whenever the output register is empty or is being drained in the same
// cycle.
// When the receiver stalls with a record waiting, o_in_ready drops and the
// lexer state holds until the record is taken.
// Reset puts the lexer at line 1, column 1, offset 0, outside any tag, and
// empties the output register. An end marker returns the lexer to that same
// state after its final record.
`default_nettype none

module xml_token_start_lexer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire xtl_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output xtl_pkg::t_out_item      o_out_data
);
    import xtl_pkg::*;

    // Lexer state.
    logic                   r_inside_tag,   n_inside_tag;
    logic                   r_inside_quote, n_inside_quote;
    t_token_kind            r_kind,         n_kind;
    logic                   r_label_open,   n_label_open;
    logic [OFFSET_BITS-1:0] r_label_offset, n_label_offset;
    logic [LINE_BITS-1:0]   r_line,         n_line;
    logic [COLUMN_BITS-1:0] r_column,       n_column;
    logic                   r_skip_blanks,  n_skip_blanks;
    logic [OFFSET_BITS-1:0] r_position,     n_position;

    // Output register.
    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out_data,  n_out_data;

    logic                   in_accept;
    logic                   emit;
    logic [COLUMN_BITS-1:0] column_bumped;
    t_char_class            char_class;

    xtl_char_class u_char_class (
        .i_byte  (i_in_data.text_byte),
        .o_class (char_class)
    );

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign column_bumped = (&r_column) ? r_column : r_column + 1'b1;

    // Next state and token record for the accepted transaction.
    always_comb begin
        n_inside_tag   = r_inside_tag;
        n_inside_quote = r_inside_quote;
        n_kind         = r_kind;
        n_label_open   = r_label_open;
        n_label_offset = r_label_offset;
        n_line         = r_line;
        n_column       = r_column;
        n_skip_blanks  = r_skip_blanks;
        n_position     = r_position;
        emit           = 1'b0;

        n_out_data.token_kind    = r_kind;
        n_out_data.line_number   = r_line;
        n_out_data.column_number = r_column;
        n_out_data.start_offset  = r_position;
        n_out_data.has_label     = 1'b1;
        n_out_data.is_final      = 1'b0;

        if (in_accept) begin
            if (i_in_data.end_of_text) begin
                // Final token, then back to the reset state.
                emit                    = 1'b1;
                n_out_data.start_offset = r_label_open ? r_label_offset : '0;
                n_out_data.has_label    = r_label_open;
                n_out_data.is_final     = 1'b1;
                n_inside_tag            = 1'b0;
                n_inside_quote          = 1'b0;
                n_kind                  = KIND_ELEMENT;
                n_label_open            = 1'b0;
                n_label_offset          = '0;
                n_line                  = LINE_BITS'(1);
                n_column                = COLUMN_BITS'(1);
                n_skip_blanks           = 1'b0;
                n_position              = '0;
            end else begin
                n_position = r_position + 1'b1;
                if (!(r_skip_blanks && char_class.is_blank)) begin
                    n_skip_blanks = 1'b0;
                    if (char_class.is_lt) begin
                        n_kind       = KIND_ELEMENT;
                        n_inside_tag = 1'b1;
                        n_label_open = 1'b0;
                        n_column     = column_bumped;
                    end else if (char_class.is_gt) begin
                        n_kind       = KIND_TEXT;
                        n_inside_tag = 1'b0;
                        n_label_open = 1'b0;
                        n_column     = column_bumped;
                    end else if (r_inside_tag && !r_inside_quote &&
                                 char_class.is_separator) begin
                        n_kind       = KIND_ATTRIBUTE;
                        n_label_open = 1'b0;
                        n_column     = column_bumped;
                    end else if (char_class.is_quote) begin
                        n_inside_quote = !r_inside_quote;
                        n_label_open   = 1'b0;
                        n_column       = column_bumped;
                    end else if (char_class.is_newline) begin
                        n_line        = (&r_line) ? r_line : r_line + 1'b1;
                        n_column      = COLUMN_BITS'(1);
                        n_label_open  = 1'b0;
                        n_skip_blanks = 1'b1;
                    end else begin
                        // A label character: the first one opens the label.
                        if (!r_label_open) begin
                            emit           = 1'b1;
                            n_label_open   = 1'b1;
                            n_label_offset = r_position;
                        end
                        n_column = column_bumped;
                    end
                end
            end
        end

        // The output register fills on a token and drains on a handshake.
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_tag   <= 1'b0;
            r_inside_quote <= 1'b0;
            r_kind         <= KIND_ELEMENT;
            r_label_open   <= 1'b0;
            r_label_offset <= '0;
            r_line         <= LINE_BITS'(1);
            r_column       <= COLUMN_BITS'(1);
            r_skip_blanks  <= 1'b0;
            r_position     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_inside_tag   <= n_inside_tag;
            r_inside_quote <= n_inside_quote;
            r_kind         <= n_kind;
            r_label_open   <= n_label_open;
            r_label_offset <= n_label_offset;
            r_line         <= n_line;
            r_column       <= n_column;
            r_skip_blanks  <= n_skip_blanks;
            r_position     <= n_position;
            r_out_valid    <= n_out_valid;
        end
    end

    // Token payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

// File: verif/xml_token_start_lexer_tb.sv
`default_nettype none

module xml_token_start_lexer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xtl_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;

    // Expected token records, oldest first.
    t_out_item expected_tokens [$];
    int        error_count = 0;
    int        items_accepted = 0;

    // Sender burst control and receiver hold-off request.
    int send_gap_max = 0;
    int burst_left = 0;
    int hold_cycles = 0;

    // Lexer state as predicted by the testbench.
    logic                   lex_in_tag;
    logic                   lex_in_quote;
    t_token_kind            lex_kind;
    logic                   lex_label_open;
    logic [OFFSET_BITS-1:0] lex_label_offset;
    logic [LINE_BITS-1:0]   lex_line;
    logic [COLUMN_BITS-1:0] lex_column;
    logic                   lex_skip_blanks;
    logic [OFFSET_BITS-1:0] lex_position;

    xml_token_start_lexer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Return the predicted lexer to its state after reset.
    function automatic void clear_lexer_state();
        lex_in_tag       = 1'b0;
        lex_in_quote     = 1'b0;
        lex_kind         = KIND_ELEMENT;
        lex_label_open   = 1'b0;
        lex_label_offset = '0;
        lex_line         = LINE_BITS'(1);
        lex_column       = COLUMN_BITS'(1);
        lex_skip_blanks  = 1'b0;
        lex_position     = '0;
    endfunction

    // Queue one token record built from the current counters.
    function automatic void queue_token(logic has_label, logic is_final);
        t_out_item tok;
        tok.token_kind    = lex_kind;
        tok.line_number   = lex_line;
        tok.column_number = lex_column;
        tok.start_offset  = has_label ? lex_label_offset : '0;
        tok.has_label     = has_label;
        tok.is_final      = is_final;
        expected_tokens.push_back(tok);
    endfunction

    // Advance the predicted lexer by one accepted transaction and queue the
    // token record it causes, if any.
    function automatic void predict_token(t_in_item item);
        logic [7:0]             c;
        logic [OFFSET_BITS-1:0] here;
        c = item.text_byte;
        if (item.end_of_text) begin
            queue_token(lex_label_open, 1'b1);
            clear_lexer_state();
            return;
        end
        here = lex_position;
        lex_position = lex_position + 1'b1;

        // Leading blanks after a newline are swallowed whole.
        if (lex_skip_blanks) begin
            if (c == CHAR_SPACE || c == CHAR_TAB) begin
                return;
            end
            lex_skip_blanks = 1'b0;
        end

        if (c == CHAR_LT) begin
            lex_kind = KIND_ELEMENT;
            lex_in_tag = 1'b1;
            lex_label_open = 1'b0;
        end else if (c == CHAR_GT) begin
            lex_kind = KIND_TEXT;
            lex_in_tag = 1'b0;
            lex_label_open = 1'b0;
        end else if (lex_in_tag && !lex_in_quote && (c == CHAR_SPACE || c == CHAR_TAB ||
                     c == CHAR_CR || c == CHAR_SLASH)) begin
            lex_kind = KIND_ATTRIBUTE;
            lex_label_open = 1'b0;
        end else if (c == CHAR_QUOTE) begin
            lex_in_quote = !lex_in_quote;
            lex_label_open = 1'b0;
        end else if (c == CHAR_LF) begin
            if (lex_line != '1) begin
                lex_line = lex_line + 1'b1;
            end
            lex_column = COLUMN_BITS'(1);
            lex_label_open = 1'b0;
            lex_skip_blanks = 1'b1;
        end else if (!lex_label_open) begin
            lex_label_open = 1'b1;
            lex_label_offset = here;
            queue_token(1'b1, 1'b0);
        end

        // Every byte except a newline or a skipped blank moves the column, up to its limit.
        if (c != CHAR_LF && lex_column != '1) begin
            lex_column = lex_column + 1'b1;
        end
    endfunction

    task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
        error_count++;
        if (error_count <= 40) begin
            $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // Compare each output transaction with the oldest expected token.
    always @(posedge clk) begin : check_tokens
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("unexpected token", '0, out_data);
            end else begin
                want = expected_tokens.pop_front();
                if (out_data.token_kind !== want.token_kind)
                    report_mismatch("token_kind", 64'(want.token_kind),
                                    64'(out_data.token_kind));
                if (out_data.line_number !== want.line_number)
                    report_mismatch("line_number", 64'(want.line_number),
                                    64'(out_data.line_number));
                if (out_data.column_number !== want.column_number)
                    report_mismatch("column_number", 64'(want.column_number),
                                    64'(out_data.column_number));
                if (out_data.start_offset !== want.start_offset)
                    report_mismatch("start_offset", 64'(want.start_offset),
                                    64'(out_data.start_offset));
                if (out_data.has_label !== want.has_label)
                    report_mismatch("has_label", 64'(want.has_label),
                                    64'(out_data.has_label));
                if (out_data.is_final !== want.is_final)
                    report_mismatch("is_final", 64'(want.is_final),
                                    64'(out_data.is_final));
            end
        end
    end

    // Receiver: phases of random stall density, plus long hold-offs on request.
    initial begin : receiver
        int phase_left;
        int stall_pct;
        phase_left = 0;
        stall_pct = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles != 0) begin
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(4, 60);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            phase_left--;
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offer one transaction and wait until it is accepted. Between bursts the
    // sender drops valid for a random gap.
    task automatic send_item(t_in_item item);
        if (send_gap_max != 0 && burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, send_gap_max)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        items_accepted++;
        predict_token(item);
    endtask

    task automatic send_char(logic [7:0] c);
        t_in_item item;
        item.text_byte = c;
        item.end_of_text = 1'b0;
        send_item(item);
    endtask

    // The byte of an end transaction is ignored, so it is random.
    task automatic send_end();
        t_in_item item;
        item.text_byte = 8'($urandom_range(0, 255));
        item.end_of_text = 1'b1;
        send_item(item);
    endtask

    // Stop sending until every expected token has come out.
    task automatic wait_tokens_drained();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [7:0] random_markup_byte();
        case ($urandom_range(0, 7))
            0: return CHAR_LT;
            1: return CHAR_GT;
            2: return CHAR_QUOTE;
            3: return CHAR_LF;
            4: return CHAR_TAB;
            5: return CHAR_CR;
            6: return CHAR_SLASH;
            default: return CHAR_SPACE;
        endcase
    endfunction

    // Mostly letters, sometimes control or high bytes that are not markup.
    function automatic logic [7:0] random_label_char();
        case ($urandom_range(0, 7))
            0: return 8'($urandom_range(8'h80, 8'hFF));
            1: return 8'($urandom_range(8'h00, 8'h08));
            default: return 8'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    // Text content: label bytes with blanks, breaks and stray quotes mixed in.
    function automatic logic [7:0] random_text_char();
        logic [7:0] c;
        if ($urandom_range(0, 2) == 0) begin
            c = random_markup_byte();
            if (c == CHAR_LT || c == CHAR_GT) begin
                c = CHAR_SPACE;
            end
            return c;
        end
        return random_label_char();
    endfunction

    task automatic send_label(int len);
        repeat (len) send_char(random_label_char());
    endtask

    // One element with attributes, text content and a closing tag.
    task automatic send_random_fragment();
        send_char(CHAR_LT);
        send_label($urandom_range(1, 4));
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: send_char(CHAR_SPACE);
                1: send_char(CHAR_TAB);
                2: send_char(CHAR_CR);
                default: send_char(CHAR_SLASH);
            endcase
            send_label($urandom_range(1, 3));
            send_char("=");
            send_char(CHAR_QUOTE);
            repeat ($urandom_range(0, 5)) send_char(random_text_char());
            send_char(CHAR_QUOTE);
        end
        if ($urandom_range(0, 3) == 0) begin
            send_char(CHAR_SLASH);
        end
        send_char(CHAR_GT);
        repeat ($urandom_range(0, 8)) send_char(random_text_char());
        send_char(CHAR_LT);
        send_char(CHAR_SLASH);
        send_label($urandom_range(1, 4));
        send_char(CHAR_GT);
        if ($urandom_range(0, 1) == 0) begin
            send_char(CHAR_LF);
            repeat ($urandom_range(0, 3)) send_char($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
        end
    endtask

    // Hand-picked text: delimiters inside and outside tags and quotes,
    // a zero byte, an all-ones byte, blank skipping after newlines, and end
    // transactions with and without an open label.
    task automatic test_directed_markup();
        logic [7:0] markup [25] = '{
            CHAR_LT, "e", CHAR_TAB, "a", CHAR_CR, CHAR_SLASH, "b", "=", CHAR_QUOTE,
            8'h00, CHAR_SPACE, "r", CHAR_QUOTE, CHAR_GT, CHAR_SPACE, 8'hFF, CHAR_SLASH,
            CHAR_CR, CHAR_LF, CHAR_SPACE, CHAR_TAB, "x", CHAR_LF, CHAR_LF, CHAR_LT};
        send_gap_max = 0;
        send_end();
        foreach (markup[i]) send_char(markup[i]);
        send_end();
        send_end();
        send_char("k");
        send_end();
        wait_tokens_drained();
    endtask

    // Receiver holds off for a long stretch while every other byte opens a
    // label, so the output register fills and the input stalls.
    task automatic test_output_hold();
        send_gap_max = 0;
        hold_cycles = 200;
        send_char(CHAR_LT);
        repeat (15) begin
            send_char(CHAR_SPACE);
            send_char(random_label_char());
        end
        send_char(CHAR_GT);
        wait (hold_cycles == 0);
        wait_tokens_drained();
    endtask

    // Well-formed fragments with random content, random end transactions,
    // and occasional pauses until the output is empty.
    task automatic test_random_documents();
        int first;
        int next_pause;
        first = items_accepted;
        next_pause = first + 200;
        send_gap_max = 6;
        while (items_accepted - first < 1000) begin
            if ($urandom_range(0, 5) == 0) begin
                send_gap_max = (send_gap_max == 0) ? $urandom_range(2, 8) : 0;
            end
            send_random_fragment();
            if ($urandom_range(0, 9) == 0) begin
                send_end();
            end
            if (items_accepted >= next_pause) begin
                wait_tokens_drained();
                next_pause = items_accepted + 200;
            end
        end
        send_end();
        wait_tokens_drained();
    endtask

    // Unstructured bytes, half of them markup, with sporadic end transactions.
    task automatic test_random_noise();
        int first;
        first = items_accepted;
        send_gap_max = 4;
        while (items_accepted - first < 350) begin
            if ($urandom_range(0, 39) == 0) begin
                send_end();
            end else if ($urandom_range(0, 1) == 0) begin
                send_char(8'($urandom_range(0, 255)));
            end else begin
                send_char(random_markup_byte());
            end
        end
        wait_tokens_drained();
    endtask

    initial begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        clear_lexer_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_markup();
        test_output_hold();
        test_random_documents();
        test_random_noise();

        wait_tokens_drained();
        repeat (5) @(posedge clk);
        if (expected_tokens.size() != 0) begin
            error_count++;
            $display("%0t ns: %0d expected tokens never arrived", $time,
                     expected_tokens.size());
        end
        if (error_count == 0) begin
            $display("xml_token_start_lexer test passed");
        end else begin
            $display("xml_token_start_lexer test failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #60_000_000;
        $display("xml_token_start_lexer test failed");
        $finish;
    end

endmodule

`default_nettype wire
